// File: sv/tdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test: shared definitions
// Widths, constants and the control/status structs between the sequencer
// and the remainder unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CAND_W      = 32;
	localparam int DIV_W       = VALUE_WIDTH / 2 + 1;
	localparam int SQ_W        = VALUE_WIDTH + 2;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);
	localparam logic [DIV_W-1:0]       FIRST_DIVISOR  = DIV_W'(3);
	localparam logic [SQ_W-1:0]        FIRST_SQUARE   = SQ_W'(9);
	localparam logic [SQ_W-1:0]        SQUARE_STEP    = SQ_W'(4);
	localparam logic [DIV_W-1:0]       DIVISOR_STEP   = DIV_W'(2);

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [DIV_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} div_rsp_t;

	function automatic logic [VALUE_WIDTH-1:0] cand_to_value(input logic [CAND_W-1:0] c);
		logic [CAND_W+VALUE_WIDTH-1:0] ext;
		ext = {{VALUE_WIDTH{1'b0}}, c};
		return ext[VALUE_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/tdp_cand_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Candidate channel
// Valid/ready channel that carries the value under test.
// ----------------------------------------------------------------------------
interface tdp_cand_if import tdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface
`default_nettype wire

// File: sv/tdp_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel that carries the primality flag.
// ----------------------------------------------------------------------------
interface tdp_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

// File: sv/tdp_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring shift/subtract remainder, one dividend bit per cycle; reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdp_rem_unit import tdp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic                   zero_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] num_q;
	logic [DIV_W-1:0]       den_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W:0]         shifted;
	logic [DIV_W-1:0]       rem_next;

	always_comb begin
		shifted  = {rem_q, num_q[VALUE_WIDTH-1]};
		rem_next = (shifted >= {1'b0, den_q}) ? DIV_W'(shifted - {1'b0, den_q})
		                                      : shifted[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
			if (cnt_q == '0) begin
				zero_q <= (rem_next == '0);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = zero_q;

endmodule
`default_nettype wire

// File: sv/trial_division_prime_test_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests odd divisors 3, 5, 7, ... against one candidate while d*d <= n,
// keeping d*d by adding 4d+4 per step; one shared remainder unit.
// ----------------------------------------------------------------------------
// Sequence: values below 2 and even values go from S_START straight to S_DONE;
//   odd values alternate S_CHECK and S_WAIT, one bit-serial remainder per
//   divisor tried, until one divides or d*d exceeds n, then go to S_DONE.
// Throughput: one candidate at a time; the next one is taken while the
//   previous verdict still waits in the output register.
// Reset: arst_n clears the sequencer and the output valid at once.
module trial_division_prime_test_unit import tdp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tdp_cand_if.sink  cand,
	tdp_res_if.source verdict
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]             state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [DIV_W-1:0]       d_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   prime_q;
	logic                   out_valid_q;
	logic                   res_q;
	logic                   past_bound;
	logic                   emit;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign past_bound = (sq_q > SQ_W'(n_q));
	assign emit       = (state_q == S_DONE) && (!out_valid_q || verdict.ready);

	assign div_req.start    = (state_q == S_CHECK) && !past_bound;
	assign div_req.dividend = n_q;
	assign div_req.divisor  = d_q;

	tdp_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			d_q     <= FIRST_DIVISOR;
			sq_q    <= FIRST_SQUARE;
			n_q     <= '0;
			prime_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cand.valid) begin
						n_q     <= cand_to_value(cand.candidate);
						d_q     <= FIRST_DIVISOR;
						sq_q    <= FIRST_SQUARE;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (n_q < SMALLEST_PRIME) begin
						prime_q <= 1'b0;
						state_q <= S_DONE;
					end else if (!n_q[0]) begin
						prime_q <= (n_q == SMALLEST_PRIME);
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (past_bound) begin
						prime_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.zero) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							d_q     <= d_q + DIVISOR_STEP;
							sq_q    <= sq_q + SQ_W'({d_q, 2'b00}) + SQUARE_STEP;
							state_q <= S_CHECK;
						end
					end
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= prime_q;
		end
	end

	assign cand.ready       = (state_q == S_IDLE);
	assign verdict.valid    = out_valid_q;
	assign verdict.is_prime = res_q;

	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_WAIT) |-> d_q[0])
		else $error("trial divisor is even");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (sq_q == (SQ_W'(d_q) * SQ_W'(d_q))))
		else $error("square bound lost track of divisor");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAIT))
		else $error("remainder done outside wait");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cand.valid && cand.ready) |=> (state_q == S_START))
		else $error("accepted candidate did not start a test");

endmodule
`default_nettype wire
